// ===== sv/pip_pkg.sv =====
// shared types, constants and edge helper for the point-in-polygon block
package pip_pkg;

  localparam int unsigned LatW  = 31;
  localparam int unsigned LonW  = 32;
  localparam int unsigned DLatW = LatW + 1;
  localparam int unsigned DLonW = LonW + 1;
  localparam int unsigned ProdW = DLatW + DLonW;

  localparam int unsigned JobFifoDepth = 2;

  // smallest ring that gets a real test
  localparam logic [1:0] RingMinVertices = 2'd3;

  typedef struct packed {
    logic                    straddle;
    logic                    dy_pos;
    logic signed [DLatW-1:0] a;
    logic signed [DLonW-1:0] dy;
    logic signed [DLatW-1:0] dx;
    logic signed [DLonW-1:0] b;
  } edge_t;

  typedef struct packed {
    edge_t reg_edge;
    edge_t close_edge;
    logic  last;
    logic  short_ring;
  } job_t;

  typedef struct packed {
    logic                    straddle;
    logic                    dy_pos;
    logic signed [ProdW-1:0] lhs;
    logic signed [ProdW-1:0] rhs;
  } prod_t;

  // operands for the crossing test of the edge from vertex i to vertex j
  function automatic edge_t make_edge(
    input logic signed [LatW-1:0] ilat,
    input logic signed [LonW-1:0] ilon,
    input logic signed [LatW-1:0] jlat,
    input logic signed [LonW-1:0] jlon,
    input logic signed [LatW-1:0] qlat,
    input logic signed [LonW-1:0] qlon
  );
    edge_t e;
    e.straddle = (ilon > qlon) != (jlon > qlon);
    e.dy       = DLonW'(jlon) - DLonW'(ilon);
    e.dy_pos   = !e.dy[DLonW-1] && (|e.dy);
    e.a        = DLatW'(qlat) - DLatW'(ilat);
    e.dx       = DLatW'(jlat) - DLatW'(ilat);
    e.b        = DLonW'(qlon) - DLonW'(ilon);
    return e;
  endfunction

endpackage

// ===== sv/pip_if.sv =====
// vertex and result channel interfaces
interface pip_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pip_pkg::LatW-1:0]    vertex_lat;
  logic signed [pip_pkg::LonW-1:0]    vertex_lon;
  logic signed [pip_pkg::LatW-1:0]    query_lat;
  logic signed [pip_pkg::LonW-1:0]    query_lon;
  logic                               last_vertex;

  modport source (output valid, vertex_lat, vertex_lon, query_lat, query_lon, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_lat, vertex_lon, query_lat, query_lon, last_vertex,
                  output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few_vertices;

  modport source (output valid, inside_res, too_few_vertices, input ready);
  modport sink   (input valid, inside_res, too_few_vertices, output ready);
endinterface

// ===== sv/pip_front.sv =====
// front end: ring tracking and edge operand setup
module pip_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  pip_in_if.sink          in_i,
  output logic            job_valid_o,
  output pip_pkg::job_t   job_o,
  input  logic            job_ready_i
);
  import pip_pkg::*;

  logic [1:0]             count_q, count_d;
  logic signed [LatW-1:0] first_lat_q, first_lat_d, prev_lat_q, prev_lat_d, qlat_q, qlat_d;
  logic signed [LonW-1:0] first_lon_q, first_lon_d, prev_lon_q, prev_lon_d, qlon_q, qlon_d;
  logic                   accept;
  logic                   ring_start;
  edge_t                  reg_e, close_e;

  assign in_i.ready  = job_ready_i;
  assign job_valid_o = in_i.valid;
  assign accept      = in_i.valid && in_i.ready;
  assign ring_start  = (count_q == 2'd0);

  always_comb begin
    reg_e   = make_edge(in_i.vertex_lat, in_i.vertex_lon, prev_lat_q, prev_lon_q,
                        qlat_q, qlon_q);
    close_e = make_edge(first_lat_q, first_lon_q, in_i.vertex_lat, in_i.vertex_lon,
                        qlat_q, qlon_q);
    reg_e.straddle   = reg_e.straddle && !ring_start;
    close_e.straddle = close_e.straddle && in_i.last_vertex &&
                       (count_q >= RingMinVertices - 2'd1);
    job_o.reg_edge   = reg_e;
    job_o.close_edge = close_e;
    job_o.last       = in_i.last_vertex;
    job_o.short_ring = count_q < RingMinVertices - 2'd1;
  end

  always_comb begin
    count_d     = count_q;
    first_lat_d = first_lat_q;
    first_lon_d = first_lon_q;
    prev_lat_d  = prev_lat_q;
    prev_lon_d  = prev_lon_q;
    qlat_d      = qlat_q;
    qlon_d      = qlon_q;
    if (accept) begin
      if (ring_start) begin
        first_lat_d = in_i.vertex_lat;
        first_lon_d = in_i.vertex_lon;
        qlat_d      = in_i.query_lat;
        qlon_d      = in_i.query_lon;
      end
      prev_lat_d = in_i.vertex_lat;
      prev_lon_d = in_i.vertex_lon;
      if (in_i.last_vertex) begin
        count_d = 2'd0;
      end else if (count_q < RingMinVertices) begin
        count_d = count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_lat_q <= first_lat_d;
    first_lon_q <= first_lon_d;
    prev_lat_q  <= prev_lat_d;
    prev_lon_q  <= prev_lon_d;
    qlat_q      <= qlat_d;
    qlon_q      <= qlon_d;
  end

endmodule

// ===== sv/pip_fifo.sv =====
// short job queue between front and back end
module pip_fifo #(
  parameter int unsigned Depth = pip_pkg::JobFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pip_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pip_pkg::job_t pop_data_o
);
  import pip_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/pip_back.sv =====
// back end: cross products, crossing compare, parity and result register
module pip_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  pip_pkg::job_t job_i,
  pip_out_if.source     out_o
);
  import pip_pkg::*;

  function automatic prod_t mul_edge(input edge_t e);
    prod_t p;
    p.straddle = e.straddle;
    p.dy_pos   = e.dy_pos;
    p.lhs      = ProdW'(e.a) * ProdW'(e.dy);
    p.rhs      = ProdW'(e.dx) * ProdW'(e.b);
    return p;
  endfunction

  function automatic logic toggles(input prod_t p);
    return p.straddle && (p.dy_pos ? (p.lhs < p.rhs) : (p.rhs < p.lhs));
  endfunction

  logic  p1_valid_q, p1_valid_d;
  prod_t p1_reg_q, p1_reg_d, p1_close_q, p1_close_d;
  logic  p1_last_q, p1_last_d, p1_short_q, p1_short_d;
  logic  parity_q, parity_d;
  logic  out_valid_q, out_valid_d;
  logic  inside_q, inside_d, few_q, few_d;
  logic  advance, load, flip;

  assign advance     = p1_valid_q && (!p1_last_q || !out_valid_q || out_o.ready);
  assign job_ready_o = !p1_valid_q || advance;
  assign load        = job_valid_i && job_ready_o;
  assign flip        = toggles(p1_reg_q) ^ toggles(p1_close_q);

  assign out_o.valid            = out_valid_q;
  assign out_o.inside_res       = inside_q;
  assign out_o.too_few_vertices = few_q;

  always_comb begin
    p1_valid_d = p1_valid_q;
    p1_reg_d   = p1_reg_q;
    p1_close_d = p1_close_q;
    p1_last_d  = p1_last_q;
    p1_short_d = p1_short_q;
    if (load) begin
      p1_valid_d = 1'b1;
      p1_reg_d   = mul_edge(job_i.reg_edge);
      p1_close_d = mul_edge(job_i.close_edge);
      p1_last_d  = job_i.last;
      p1_short_d = job_i.short_ring;
    end else if (advance) begin
      p1_valid_d = 1'b0;
    end
  end

  always_comb begin
    parity_d    = parity_q;
    out_valid_d = out_valid_q;
    inside_d    = inside_q;
    few_d       = few_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      if (p1_last_q) begin
        parity_d    = 1'b0;
        out_valid_d = 1'b1;
        inside_d    = !p1_short_q && (parity_q ^ flip);
        few_d       = p1_short_q;
      end else begin
        parity_d = parity_q ^ flip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_valid_q  <= p1_valid_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_reg_q   <= p1_reg_d;
    p1_close_q <= p1_close_d;
    p1_last_q  <= p1_last_d;
    p1_short_q <= p1_short_d;
    inside_q   <= inside_d;
    few_q      <= few_d;
  end

endmodule

// ===== sv/point_in_polygon_ray_cast_top.sv =====
// even-odd point-in-polygon test, one ring vertex per transaction
// throughput: one vertex per cycle while no finished result is held by out_o.ready
// result path: a ring's last vertex goes through a queue entry, the product register
//   and the result register in the back end before the result is valid
// reset: async active low, clears ring count, parity, queue and valid flags
module point_in_polygon_ray_cast_top #(
  parameter int unsigned QueueDepth = pip_pkg::JobFifoDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pip_in_if.sink    in_i,
  pip_out_if.source out_o
);
  import pip_pkg::*;

  logic job_valid, job_ready, deq_valid, deq_ready;
  job_t job, deq_job;

  pip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  pip_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (deq_valid),
    .pop_ready_i  (deq_ready),
    .pop_data_o   (deq_job)
  );

  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (deq_valid),
    .job_ready_o (deq_ready),
    .job_i       (deq_job),
    .out_o       (out_o)
  );

endmodule

// ===== sv/pip_checker.sv =====
// port-level checks for the point-in-polygon block and their bind
module pip_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_vertex_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_inside_res_i,
  input logic out_too_few_vertices_i
);

  // rings whose last vertex went in and whose result has not gone out
  logic [7:0] pend_q, pend_d;
  logic       ring_in, res_out;

  assign ring_in = in_valid_i && in_ready_i && in_last_vertex_i;
  assign res_out = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (ring_in && !res_out) begin
      pend_d = pend_q + 8'd1;
    end else if (res_out && !ring_in) begin
      pend_d = pend_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 8'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_inside_res_i) &&
                                    $stable(out_too_few_vertices_i))
    else $error("result changed while stalled");

  a_short_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_inside_res_i && out_too_few_vertices_i))
    else $error("short ring reported inside");

  a_result_has_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 8'd0)
    else $error("result without a finished ring");

endmodule

bind point_in_polygon_ray_cast_top pip_checker u_pip_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_i.valid),
  .in_ready_i             (in_i.ready),
  .in_last_vertex_i       (in_i.last_vertex),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .out_inside_res_i       (out_o.inside_res),
  .out_too_few_vertices_i (out_o.too_few_vertices)
);

// ===== bench/point_in_polygon_ray_cast_top_tb.sv =====
// self-checking testbench for the even-odd point-in-polygon ray-cast block
module point_in_polygon_ray_cast_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  localparam int unsigned ItemTarget  = 1550;
  localparam int unsigned PhaseLen    = 150;
  localparam int unsigned PressureAt  = 600;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;

  localparam longint LatMin = -(longint'(1) <<< (LatW - 1));
  localparam longint LatMax = (longint'(1) <<< (LatW - 1)) - 1;
  localparam longint LonMin = -(longint'(1) <<< (LonW - 1));
  localparam longint LonMax = (longint'(1) <<< (LonW - 1)) - 1;

  typedef enum logic [1:0] {
    PhFree,
    PhSendIdle,
    PhRecvStall,
    PhBoth
  } idle_phase_e;

  typedef struct {
    logic signed [LatW-1:0] vertex_lat;
    logic signed [LonW-1:0] vertex_lon;
    logic signed [LatW-1:0] query_lat;
    logic signed [LonW-1:0] query_lon;
    logic                   last_vertex;
  } vertex_item_t;

  typedef struct {
    logic inside_res;
    logic too_few_vertices;
  } ring_verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pip_in_if  vin();
  pip_out_if vout();

  point_in_polygon_ray_cast_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (vin),
    .out_o  (vout)
  );

  always #4 clk_i = ~clk_i;

  vertex_item_t  pending_vertices[$];
  ring_verdict_t verdict_q[$];
  vertex_item_t  cur_vertex;
  bit            gen_ring_open;

  int unsigned n_total;
  int unsigned n_accepted;
  int unsigned n_rings_closed;
  int unsigned n_verdicts_seen;
  int unsigned n_errors;
  int unsigned n_cycles;
  int unsigned hold_left;
  bit          hold_done;

  // ring tracking state of the predictor
  longint     ring_first_lat, ring_first_lon;
  longint     ring_prev_lat, ring_prev_lon;
  longint     ring_query_lat, ring_query_lon;
  logic       ring_parity;
  logic [1:0] ring_count;

  function automatic idle_phase_e phase_of(input int unsigned accepted);
    return idle_phase_e'((accepted / PhaseLen) % 4);
  endfunction

  function automatic int unsigned send_idle_pct(input idle_phase_e ph);
    case (ph)
      PhSendIdle: return 72;
      PhBoth:     return 38;
      default:    return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(input idle_phase_e ph);
    case (ph)
      PhRecvStall: return 72;
      PhBoth:      return 38;
      default:     return 0;
    endcase
  endfunction

  // exact crossing test for the edge i->j against a ray from the query point
  function automatic bit edge_crosses(input longint ilat, input longint ilon,
                                      input longint jlat, input longint jlon,
                                      input longint qlat, input longint qlon);
    logic signed [69:0] a, b, c, d, lhs, rhs;
    longint             dy;
    if ((ilon > qlon) == (jlon > qlon)) return 1'b0;
    dy  = jlon - ilon;
    a   = qlat - ilat;
    b   = dy;
    c   = jlat - ilat;
    d   = qlon - ilon;
    lhs = a * b;
    rhs = c * d;
    return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
  endfunction

  task automatic track_vertex(input vertex_item_t v);
    longint        vlat, vlon;
    ring_verdict_t r;
    vlat = v.vertex_lat;
    vlon = v.vertex_lon;
    if (ring_count == 2'd0) begin
      ring_first_lat = vlat;
      ring_first_lon = vlon;
      ring_query_lat = v.query_lat;
      ring_query_lon = v.query_lon;
      ring_parity    = 1'b0;
    end else if (edge_crosses(vlat, vlon, ring_prev_lat, ring_prev_lon,
                              ring_query_lat, ring_query_lon)) begin
      ring_parity = ~ring_parity;
    end
    ring_prev_lat = vlat;
    ring_prev_lon = vlon;
    if (ring_count < RingMinVertices) ring_count = ring_count + 2'd1;
    if (v.last_vertex) begin
      if (ring_count < RingMinVertices) begin
        r.inside_res       = 1'b0;
        r.too_few_vertices = 1'b1;
      end else begin
        // closing edge back to the first vertex
        if (edge_crosses(ring_first_lat, ring_first_lon, vlat, vlon,
                         ring_query_lat, ring_query_lon))
          ring_parity = ~ring_parity;
        r.inside_res       = ring_parity;
        r.too_few_vertices = 1'b0;
      end
      verdict_q.push_back(r);
      ring_count  = 2'd0;
      ring_parity = 1'b0;
    end
  endtask

  function automatic longint any_lat();
    logic signed [LatW-1:0] f;
    f = LatW'($urandom);
    return f;
  endfunction

  function automatic longint any_lon();
    logic signed [LonW-1:0] f;
    f = $urandom;
    return f;
  endfunction

  // query fields only count on a ring's first vertex, so later ones get junk
  task automatic add_vertex(input longint lat, input longint lon,
                            input longint qlat, input longint qlon, input bit last);
    vertex_item_t v;
    v.vertex_lat  = lat[LatW-1:0];
    v.vertex_lon  = lon[LonW-1:0];
    v.last_vertex = last;
    if (gen_ring_open) begin
      v.query_lat = LatW'(any_lat());
      v.query_lon = LonW'(any_lon());
    end else begin
      v.query_lat = qlat[LatW-1:0];
      v.query_lon = qlon[LonW-1:0];
    end
    gen_ring_open = !last;
    pending_vertices.push_back(v);
  endtask

  task automatic add_random_ring();
    int unsigned sel, pick, len, scale;
    bit          wide;
    longint      qlat, qlon, lat, lon, plat, plon;
    sel = $urandom_range(0, 99);
    if (sel < 8)       len = $urandom_range(1, 2);
    else if (sel < 85) len = $urandom_range(3, 10);
    else if (sel < 97) len = $urandom_range(11, 30);
    else               len = $urandom_range(31, 60);
    wide  = $urandom_range(0, 99) < 20;
    scale = 1 << $urandom_range(0, 26);
    if (wide) begin
      qlat = any_lat();
      qlon = any_lon();
    end else begin
      qlat = longint'($urandom_range(0, 32'd1800000000)) - 900000000;
      qlon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    end
    plat = qlat;
    plon = qlon;
    for (int i = 0; i < len; i++) begin
      if (wide) begin
        lat = any_lat();
        lon = any_lon();
      end else begin
        // local polygon around the query, with vertices on its longitude,
        // equal-longitude edges and repeated vertices mixed in
        pick = $urandom_range(0, 99);
        lat  = qlat + longint'($urandom_range(0, 2 * scale)) - scale;
        lon  = qlon + longint'($urandom_range(0, 2 * scale)) - scale;
        if (pick < 15) begin
          lon = qlon;
        end else if (pick < 25 && i > 0) begin
          lon = plon;
        end else if (pick < 30 && i > 0) begin
          lat = plat;
          lon = plon;
        end
      end
      add_vertex(lat, lon, qlat, qlon, i == len - 1);
      plat = lat;
      plon = lon;
    end
  endtask

  // hold-off stretch: the receiver goes quiet while vertices keep coming
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= PressureAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit take, offer;
    if (!rst_ni) begin
      vin.valid      <= 1'b0;
      n_accepted     <= 0;
      n_rings_closed <= 0;
      ring_count     = 2'd0;
      ring_parity    = 1'b0;
    end else begin
      take = vin.valid && vin.ready;
      if (take) begin
        track_vertex(cur_vertex);
        n_accepted <= n_accepted + 1;
        if (cur_vertex.last_vertex) n_rings_closed <= n_rings_closed + 1;
      end
      if (!(vin.valid && !take)) begin
        offer = pending_vertices.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct(phase_of(n_accepted));
        if (offer) begin
          cur_vertex       = pending_vertices.pop_front();
          vin.valid       <= 1'b1;
          vin.vertex_lat  <= cur_vertex.vertex_lat;
          vin.vertex_lon  <= cur_vertex.vertex_lon;
          vin.query_lat   <= cur_vertex.query_lat;
          vin.query_lon   <= cur_vertex.query_lon;
          vin.last_vertex <= cur_vertex.last_vertex;
        end else begin
          vin.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout.ready <= 1'b0;
    end else begin
      vout.ready <= (hold_left == 0) &&
                    $urandom_range(0, 99) >= recv_stall_pct(phase_of(n_accepted));
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ring_verdict_t want;
    if (!rst_ni) begin
      n_verdicts_seen <= 0;
    end else if (vout.valid && vout.ready) begin
      n_verdicts_seen <= n_verdicts_seen + 1;
      if (verdict_q.size() == 0) begin
        if (n_errors < MaxReports)
          $display("unexpected result transaction: inside=%0b few=%0b",
                   vout.inside_res, vout.too_few_vertices);
        n_errors = n_errors + 1;
      end else begin
        want = verdict_q.pop_front();
        if (vout.inside_res !== want.inside_res ||
            vout.too_few_vertices !== want.too_few_vertices) begin
          if (n_errors < MaxReports)
            $display("result %0d mismatch: expected inside=%0b few=%0b, got inside=%0b few=%0b",
                     n_verdicts_seen, want.inside_res, want.too_few_vertices,
                     vout.inside_res, vout.too_few_vertices);
          n_errors = n_errors + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni          = 1'b0;
    vin.valid       = 1'b0;
    vin.vertex_lat  = '0;
    vin.vertex_lon  = '0;
    vin.query_lat   = '0;
    vin.query_lon   = '0;
    vin.last_vertex = 1'b0;
    vout.ready      = 1'b0;
    n_errors        = 0;
    n_cycles        = 0;
    gen_ring_open   = 1'b0;

    // short rings of one and two vertices
    add_vertex(5, 5, 0, 0, 1'b1);
    add_vertex(-7, 3, 1, 1, 1'b0);
    add_vertex(9, -4, 0, 0, 1'b1);
    // square around the query, then the same square with the query above it
    add_vertex(-100, -100, 0, 0, 1'b0);
    add_vertex(-100, 100, 0, 0, 1'b0);
    add_vertex(100, 100, 0, 0, 1'b0);
    add_vertex(100, -100, 0, 0, 1'b1);
    add_vertex(-100, -100, 200, 0, 1'b0);
    add_vertex(-100, 100, 200, 0, 1'b0);
    add_vertex(100, 100, 200, 0, 1'b0);
    add_vertex(100, -100, 200, 0, 1'b1);
    // corner values of the vertex coordinate fields, and of the query fields on the second ring
    add_vertex(LatMin, LonMin, -1, 0, 1'b0);
    add_vertex(LatMax, LonMax, -1, 0, 1'b0);
    add_vertex(LatMin, LonMax, -1, 0, 1'b1);
    add_vertex(LatMax, LonMin, LatMax, LonMin, 1'b0);
    add_vertex(LatMin, LonMax, LatMax, LonMin, 1'b0);
    add_vertex(LatMax, LonMax, LatMin, LonMax, 1'b1);
    // equal-longitude edge with the query on a vertex longitude
    add_vertex(0, 0, 10, 0, 1'b0);
    add_vertex(100, 0, 10, 0, 1'b0);
    add_vertex(50, 100, 10, 0, 1'b1);

    while (pending_vertices.size() < ItemTarget) add_random_ring();
    n_total = pending_vertices.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_total || n_verdicts_seen != n_rings_closed) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (verdict_q.size() != 0) $display("%0d results never arrived", verdict_q.size());
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== point_in_polygon_ray_cast_top.f =====
sv/pip_pkg.sv
sv/pip_if.sv
sv/pip_front.sv
sv/pip_fifo.sv
sv/pip_back.sv
sv/point_in_polygon_ray_cast_top.sv
sv/pip_checker.sv
bench/point_in_polygon_ray_cast_top_tb.sv
